FILE: src/cso_pkg.sv
package cso_pkg;

  localparam int unsigned NUM_COEFS    = 12;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned CORDIC_STEPS = 30;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_COEF_LOW  = 2'd1;
  localparam logic [1:0] REG_COEF_MID  = 2'd2;
  localparam logic [1:0] REG_COEF_HIGH = 2'd3;

  localparam logic [3:0] MODE_SCALAR_X       = 4'd1;
  localparam logic [3:0] MODE_SCALAR_XY      = 4'd2;
  localparam logic [3:0] MODE_SCALAR_XYZ     = 4'd3;
  localparam logic [3:0] MODE_PROP_XY        = 4'd4;
  localparam logic [3:0] MODE_PROP_XYZ       = 4'd5;
  localparam logic [3:0] MODE_LIN_SIMPLE_XY  = 4'd6;
  localparam logic [3:0] MODE_LIN_SIMPLE_XYZ = 4'd7;
  localparam logic [3:0] MODE_LIN_FULL_XY    = 4'd8;
  localparam logic [3:0] MODE_LIN_FULL_XYZ   = 4'd9;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [15:0] ONE_Q11    = 16'sd2048;

  typedef enum logic [2:0] {
    OPA_DX, OPA_DY, OPA_CX, OPA_CY, OPA_COEF
  } opa_e;

  typedef enum logic [2:0] {
    OPB_C, OPB_S, OPB_NS, OPB_ONE, OPB_DX, OPB_DY, OPB_DZ8
  } opb_e;

  typedef enum logic [2:0] {
    ST_NONE, ST_RX, ST_RY, ST_CX, ST_CY, ST_CZ
  } store_e;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       cinit;
    logic       csel;
    logic       cstep;
    logic       cfin;
    logic [4:0] iter;
    logic       mul;
    logic       clr;
    opa_e       sel_a;
    opb_e       sel_b;
    logic [1:0] row;
    logic [1:0] col;
    store_e     store;
    logic       copy;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] v;
    v = 32'sd0;
    case (i)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      5'd24: v = 32'sd64;
      5'd25: v = 32'sd32;
      5'd26: v = 32'sd16;
      5'd27: v = 32'sd8;
      5'd28: v = 32'sd4;
      5'd29: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Entry of the 3 by 4 correction matrix; rows are x, y and heading, columns
  // are offset, x, y and heading gains.
  function automatic logic signed [15:0] mat_entry(
    input logic [3:0]                    mode,
    input logic [NUM_COEFS*COEF_W-1:0]   k,
    input logic [1:0]                    r,
    input logic [1:0]                    c
  );
    logic signed [15:0] v;
    logic [3:0]         ix;
    v  = ({1'b0, c} == {1'b0, r} + 3'd1) ? ONE_Q11 : 16'sd0;
    ix = {r, c};
    case (mode)
      MODE_SCALAR_X: begin
        if (r == 2'd0 && c == 2'd1) v = k[15:0];
      end
      MODE_SCALAR_XY: begin
        if ((r == 2'd0 && c == 2'd1) || (r == 2'd1 && c == 2'd2)) v = k[15:0];
      end
      MODE_SCALAR_XYZ: begin
        if ({1'b0, c} == {1'b0, r} + 3'd1) v = k[15:0];
      end
      MODE_PROP_XY: begin
        if (r == 2'd0 && c == 2'd1) v = k[15:0];
        if (r == 2'd1 && c == 2'd2) v = k[31:16];
      end
      MODE_PROP_XYZ: begin
        if (r == 2'd0 && c == 2'd1) v = k[15:0];
        if (r == 2'd1 && c == 2'd2) v = k[31:16];
        if (r == 2'd2 && c == 2'd3) v = k[47:32];
      end
      MODE_LIN_SIMPLE_XY, MODE_LIN_SIMPLE_XYZ: begin
        if (r == 2'd0 && c == 2'd0) v = k[15:0];
        if (r == 2'd0 && c == 2'd1) v = k[31:16];
        if (r == 2'd1 && c == 2'd0) v = k[47:32];
        if (r == 2'd1 && c == 2'd2) v = k[63:48];
        if (mode == MODE_LIN_SIMPLE_XYZ) begin
          if (r == 2'd2 && c == 2'd0) v = k[79:64];
          if (r == 2'd2 && c == 2'd3) v = k[95:80];
        end
      end
      MODE_LIN_FULL_XY: begin
        if (r != 2'd2) v = k[ix*COEF_W +: COEF_W];
      end
      MODE_LIN_FULL_XYZ: begin
        v = k[ix*COEF_W +: COEF_W];
      end
      default: v = v;
    endcase
    return v;
  endfunction

endpackage

FILE: src/cso_regs.sv
module cso_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [63:0]                            pwdata,
  output logic [63:0]                            prdata,
  output logic                                   pready,
  output logic [3:0]                             mode_o,
  output logic [cso_pkg::NUM_COEFS*cso_pkg::COEF_W-1:0] coefs_o
);
  import cso_pkg::*;

  logic [3:0]  mode_q;
  logic [63:0] low_q, mid_q, high_q;

  assign pready  = 1'b1;
  assign mode_o  = mode_q;
  assign coefs_o = {high_q, mid_q, low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      low_q  <= '0;
      mid_q  <= '0;
      high_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_MODE:      mode_q <= pwdata[3:0];
        REG_COEF_LOW:  low_q  <= pwdata;
        REG_COEF_MID:  mid_q  <= pwdata;
        REG_COEF_HIGH: high_q <= pwdata;
        default:       mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_MODE:      prdata = {60'd0, mode_q};
      REG_COEF_LOW:  prdata = low_q;
      REG_COEF_MID:  prdata = mid_q;
      REG_COEF_HIGH: prdata = high_q;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: src/cso_ctrl.sv
module cso_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  cso_pkg::dp_stat_t stat_i,
  output cso_pkg::dp_cmd_t  cmd_o
);
  import cso_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_CORR = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] row_q, row_d;
  logic       pass_q, pass_d;
  logic [1:0] kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
      pass_q  <= 1'b0;
      kind_q  <= CMD_SAMPLE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      pass_q  <= pass_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    pass_d     = pass_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel_a = OPA_DX;
    cmd_o.sel_b = OPB_C;
    cmd_o.store = ST_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          kind_d     = in_cmd_i;
          unique case (in_cmd_i)
            CMD_SAMPLE, CMD_STEP: state_d = S_LOAD;
            CMD_RESET:            state_d = S_FIN;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        row_d      = '0;
        if (kind_q == CMD_SAMPLE) begin
          cmd_o.cinit = 1'b1;
          pass_d      = 1'b0;
          state_d     = S_CORD;
        end else begin
          state_d = S_CORR;
        end
      end
      S_CORD: begin
        if (cnt_q == 5'(CORDIC_STEPS)) begin
          cmd_o.cfin = 1'b1;
          cnt_d      = '0;
          state_d    = S_ROT;
        end else begin
          cmd_o.cstep = 1'b1;
          cmd_o.iter  = cnt_q;
          cnt_d       = cnt_q + 5'd1;
        end
      end
      S_ROT: begin
        cnt_d = cnt_q + 5'd1;
        case (cnt_q)
          5'd0: begin
            cmd_o.mul   = 1'b1;
            cmd_o.clr   = 1'b1;
            cmd_o.sel_a = pass_q ? OPA_CX : OPA_DX;
            cmd_o.sel_b = OPB_C;
          end
          5'd1: begin
            cmd_o.mul   = 1'b1;
            cmd_o.sel_a = pass_q ? OPA_CY : OPA_DY;
            cmd_o.sel_b = pass_q ? OPB_NS : OPB_S;
          end
          5'd3: cmd_o.store = ST_RX;
          5'd4: begin
            cmd_o.mul   = 1'b1;
            cmd_o.clr   = 1'b1;
            cmd_o.sel_a = pass_q ? OPA_CX : OPA_DX;
            cmd_o.sel_b = pass_q ? OPB_S : OPB_NS;
          end
          5'd5: begin
            cmd_o.mul   = 1'b1;
            cmd_o.sel_a = pass_q ? OPA_CY : OPA_DY;
            cmd_o.sel_b = OPB_C;
          end
          5'd7: begin
            cmd_o.store = ST_RY;
            if (pass_q) state_d = S_FIN;
          end
          5'd8: begin
            cmd_o.copy = 1'b1;
            cnt_d      = '0;
            row_d      = '0;
            state_d    = S_CORR;
          end
          default: cmd_o.mul = 1'b0;
        endcase
      end
      S_CORR: begin
        cnt_d     = cnt_q + 5'd1;
        cmd_o.row = row_q;
        cmd_o.col = cnt_q[1:0];
        if (cnt_q < 5'd4) begin
          cmd_o.mul   = 1'b1;
          cmd_o.clr   = (cnt_q == 5'd0);
          cmd_o.sel_a = OPA_COEF;
          case (cnt_q[1:0])
            2'd0:    cmd_o.sel_b = OPB_ONE;
            2'd1:    cmd_o.sel_b = OPB_DX;
            2'd2:    cmd_o.sel_b = OPB_DY;
            default: cmd_o.sel_b = OPB_DZ8;
          endcase
        end else if (cnt_q == 5'd5) begin
          cnt_d = '0;
          case (row_q)
            2'd0:    cmd_o.store = ST_CX;
            2'd1:    cmd_o.store = ST_CY;
            default: cmd_o.store = ST_CZ;
          endcase
          if (row_q == 2'd2) begin
            cmd_o.cinit = 1'b1;
            cmd_o.csel  = 1'b1;
            pass_d      = 1'b1;
            state_d     = S_CORD;
          end else begin
            row_d = row_q + 2'd1;
          end
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/cso_dp.sv
module cso_dp (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  cso_pkg::dp_cmd_t                              cmd_i,
  output cso_pkg::dp_stat_t                             stat_o,
  input  logic [1:0]                                    in_cmd_i,
  input  logic signed [31:0]                            in_x_i,
  input  logic signed [31:0]                            in_y_i,
  input  logic signed [15:0]                            in_h_i,
  input  logic                                          in_ls_i,
  input  logic [3:0]                                    mode_i,
  input  logic [cso_pkg::NUM_COEFS*cso_pkg::COEF_W-1:0] coefs_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic signed [31:0]                            out_x_o,
  output logic signed [31:0]                            out_y_o,
  output logic signed [15:0]                            out_h_o
);
  import cso_pkg::*;

  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [17:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r > PI_Q13) r = r - TWO_PI_Q13;
    if (r < -PI_Q13) r = r + TWO_PI_Q13;
    return r;
  endfunction

  logic               started_q, prev_q, last_q, ov_q;
  logic signed [31:0] ax_q, ay_q, ix_q, iy_q;
  logic signed [15:0] ah_q, ih_q;
  logic signed [31:0] px_q, py_q;
  logic signed [15:0] ph_q;
  logic               ls_q;
  logic [1:0]         kind_q;
  logic signed [31:0] dx_q, dy_q, cx_q, cy_q, rx_q, ry_q;
  logic signed [17:0] dz_q;
  logic signed [15:0] cz_q;
  logic signed [33:0] xc_q, yc_q;
  logic signed [34:0] zc_q;
  logic               neg_q;
  logic signed [31:0] c_q, s_q, ns_q;
  logic signed [63:0] prod_q, acc_q;
  logic               add_q, clr_q;
  logic signed [31:0] ox_q, oy_q;
  logic signed [15:0] oh_q;

  logic signed [31:0] opa, opb;
  logic signed [63:0] mul_w;
  logic signed [63:0] rnd30, rnd11, rnd14;
  logic signed [49:0] zt;
  logic signed [15:0] cz_w;
  logic signed [15:0] ang;
  logic signed [34:0] z0;
  logic signed [33:0] xs, ys;
  logic signed [34:0] at;
  logic signed [31:0] nx, ny;
  logic signed [15:0] nh, rh;
  logic               commit;

  assign stat_o.out_busy = ov_q && !out_ready_i;
  assign out_valid_o     = ov_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign out_h_o         = oh_q;

  always_comb begin
    case (cmd_i.sel_a)
      OPA_DX:  opa = dx_q;
      OPA_DY:  opa = dy_q;
      OPA_CX:  opa = cx_q;
      OPA_CY:  opa = cy_q;
      default: opa = 32'(mat_entry(mode_i, coefs_i, cmd_i.row, cmd_i.col));
    endcase
    case (cmd_i.sel_b)
      OPB_C:   opb = c_q;
      OPB_S:   opb = s_q;
      OPB_NS:  opb = ns_q;
      OPB_ONE: opb = 32'sd65536;
      OPB_DX:  opb = dx_q;
      OPB_DY:  opb = dy_q;
      default: opb = 32'(dz_q) <<< 3;
    endcase
  end

  assign mul_w = opa * opb;
  assign rnd30 = acc_q + 64'sd536870912;
  assign rnd11 = acc_q + 64'sd1024;
  assign rnd14 = acc_q + 64'sd8192;
  assign zt    = rnd14[63:14];

  always_comb begin
    if (zt > 50'(PI_Q13)) cz_w = 16'(PI_Q13);
    else if (zt < -50'(PI_Q13)) cz_w = 16'(-PI_Q13);
    else cz_w = zt[15:0];
  end

  assign ang = cmd_i.csel ? ih_q : ah_q;
  assign z0  = 35'(ang) <<< 17;
  assign xs  = xc_q >>> cmd_i.iter;
  assign ys  = yc_q >>> cmd_i.iter;
  assign at  = 35'(atan_q30(cmd_i.iter));

  assign nx     = ix_q + rx_q;
  assign ny     = iy_q + ry_q;
  assign nh     = 16'(wrap_ang(18'(ih_q) + 18'(cz_q)));
  assign rh     = 16'(wrap_ang(18'(ph_q)));
  assign commit = (kind_q == CMD_STEP) || (kind_q == CMD_SAMPLE && !last_q && ls_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      prev_q    <= 1'b0;
      last_q    <= 1'b0;
      ax_q      <= '0;
      ay_q      <= '0;
      ah_q      <= '0;
      ix_q      <= '0;
      iy_q      <= '0;
      ih_q      <= '0;
      ov_q      <= 1'b0;
      add_q     <= 1'b0;
      clr_q     <= 1'b0;
    end else begin
      add_q <= cmd_i.mul;
      clr_q <= cmd_i.clr;
      if (out_ready_i) ov_q <= 1'b0;
      if (cmd_i.take) begin
        if (in_cmd_i == CMD_SAMPLE) begin
          prev_q <= in_ls_i;
          if (!started_q) begin
            started_q <= 1'b1;
            ax_q      <= in_x_i;
            ay_q      <= in_y_i;
            ah_q      <= in_h_i;
            last_q    <= in_ls_i;
          end else begin
            last_q <= prev_q;
          end
        end else if (in_cmd_i == CMD_STEP) begin
          if (!started_q) begin
            started_q <= 1'b1;
            prev_q    <= 1'b1;
          end
          ax_q <= ix_q;
          ay_q <= iy_q;
          ah_q <= ih_q;
        end
      end
      if (cmd_i.finish) begin
        ov_q <= 1'b1;
        if (kind_q == CMD_RESET) begin
          started_q <= 1'b0;
          ix_q      <= px_q;
          iy_q      <= py_q;
          ih_q      <= rh;
        end else if (commit) begin
          ix_q <= nx;
          iy_q <= ny;
          ih_q <= nh;
          if (kind_q == CMD_SAMPLE) begin
            ax_q <= px_q;
            ay_q <= py_q;
            ah_q <= ph_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      px_q   <= in_x_i;
      py_q   <= in_y_i;
      ph_q   <= in_h_i;
      ls_q   <= in_ls_i;
      kind_q <= in_cmd_i;
    end
    if (cmd_i.load) begin
      if (kind_q == CMD_SAMPLE) begin
        dx_q <= px_q - ax_q;
        dy_q <= py_q - ay_q;
        dz_q <= wrap_ang(18'(ph_q) - 18'(ah_q));
      end else begin
        dx_q <= px_q;
        dy_q <= py_q;
        dz_q <= 18'(ph_q);
      end
    end
    if (cmd_i.copy) begin
      dx_q <= rx_q;
      dy_q <= ry_q;
    end
    if (cmd_i.cinit) begin
      xc_q <= CORDIC_GAIN;
      yc_q <= '0;
      if (z0 > HALF_PI_Q30) begin
        zc_q  <= z0 - PI_Q30;
        neg_q <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        zc_q  <= z0 + PI_Q30;
        neg_q <= 1'b1;
      end else begin
        zc_q  <= z0;
        neg_q <= 1'b0;
      end
    end
    if (cmd_i.cstep) begin
      if (zc_q >= 0) begin
        xc_q <= xc_q - ys;
        yc_q <= yc_q + xs;
        zc_q <= zc_q - at;
      end else begin
        xc_q <= xc_q + ys;
        yc_q <= yc_q - xs;
        zc_q <= zc_q + at;
      end
    end
    if (cmd_i.cfin) begin
      c_q  <= neg_q ? -xc_q[31:0] : xc_q[31:0];
      s_q  <= neg_q ? -yc_q[31:0] : yc_q[31:0];
      ns_q <= neg_q ? yc_q[31:0] : -yc_q[31:0];
    end
    if (cmd_i.mul) prod_q <= mul_w;
    if (add_q) acc_q <= (clr_q ? 64'sd0 : acc_q) + prod_q;
    case (cmd_i.store)
      ST_RX:   rx_q <= rnd30[61:30];
      ST_RY:   ry_q <= rnd30[61:30];
      ST_CX:   cx_q <= rnd11[42:11];
      ST_CY:   cy_q <= rnd11[42:11];
      ST_CZ:   cz_q <= cz_w;
      default: ;
    endcase
    if (cmd_i.finish) begin
      if (kind_q == CMD_RESET) begin
        ox_q <= px_q;
        oy_q <= py_q;
        oh_q <= rh;
      end else begin
        ox_q <= nx;
        oy_q <= ny;
        oh_q <= nh;
      end
    end
  end

endmodule

FILE: src/corrected_step_odometry.sv
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid / tready         command word: pose or delta, support foot
// m_axis    out        tvalid / tready         corrected pose word
// apb       in         psel, penable, pready   correction mode and coefficients
//
// A walking-pose sample runs two 30-iteration CORDIC passes, a full-step delta one and a
// pose reset none; an unknown command is dropped and the block stays ready.
// Samples and deltas share the single 32 by 32 multiplier, which serves both rotations
// and the twelve correction products.
// Reset clears the pose state and the registers at once; no clearing pass follows.
// A finished word waits in the output register while the next word is taken in;
// the block stalls only when a second result is ready before the first is taken.
module corrected_step_odometry (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // pose_x, pose_y, pose_heading, left_support, zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // out_x, out_y, out_heading
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cso_pkg::*;

  dp_cmd_t                        cmd;
  dp_stat_t                       stat;
  logic [3:0]                     mode;
  logic [NUM_COEFS*COEF_W-1:0]    coefs;
  logic signed [31:0]             out_x, out_y;
  logic signed [15:0]             out_h;

  cso_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode),
    .coefs_o (coefs)
  );

  cso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cso_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_cmd_i    (s_axis_tuser),
    .in_x_i      (s_axis_tdata[31:0]),
    .in_y_i      (s_axis_tdata[63:32]),
    .in_h_i      (s_axis_tdata[79:64]),
    .in_ls_i     (s_axis_tdata[80]),
    .mode_i      (mode),
    .coefs_i     (coefs),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_h_o     (out_h)
  );

  assign m_axis_tdata = {out_h, out_y, out_x};

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[79:64]) <= 16'sd25736 &&
                       $signed(m_axis_tdata[79:64]) >= -16'sd25736))
    else $error("heading outside the wrapped range");

  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_NONE) |=> s_axis_tready)
    else $error("unknown command did not return to idle");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SAMPLE) |=> !s_axis_tready)
    else $error("input taken while a sample is in progress");

endmodule

FILE: dv/odo_checker.sv
`timescale 1ns / 1ps

module odo_checker
  import cso_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam longint Q13_PI      = 25736;
  localparam longint Q13_TWO_PI  = 51472;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 1686629713;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint ARCTAN_Q30 [0:29] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  typedef struct packed {
    logic [15:0] h;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  logic [3:0]  mode_q;
  logic [63:0] coef_q [3];
  bit          started_q;
  bit          prev_left_q;
  longint      anc_x, anc_y, anc_h;
  longint      odo_x, odo_y, odo_h;
  pose_t       pose_fifo [$];

  assign pending = pose_fifo.size();

  function automatic longint wrap32(input longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint wrap_pi(input longint a);
    longint r;
    r = a;
    if (r > Q13_PI) r -= Q13_TWO_PI;
    if (r < -Q13_PI) r += Q13_TWO_PI;
    return r;
  endfunction

  function automatic void cordic_cos_sin(input longint a, output longint c, output longint s);
    longint z, x, y, t;
    bit     flip;
    z = a * 131072;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN_Q30[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN_Q30[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void rotate_vec(input longint vx, input longint vy, input longint c,
                                     input longint s, output longint rx, output longint ry);
    rx = wrap32((vx * c - vy * s + (64'sd1 <<< 29)) >>> 30);
    ry = wrap32((vx * s + vy * c + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic void apply_correction(input longint dx, input longint dy, input longint dz,
                                           output longint ox, output longint oy,
                                           output longint oz);
    longint      m [3][4];
    longint      k [12];
    longint      acc [3];
    logic [63:0] w;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        m[r][c] = (c == r + 1) ? 2048 : 0;
    for (int i = 0; i < 12; i++) begin
      w = coef_q[i / 4] >> (16 * (i % 4));
      k[i] = longint'($signed(w[15:0]));
    end
    case (mode_q)
      MODE_SCALAR_X: m[0][1] = k[0];
      MODE_SCALAR_XY: begin
        m[0][1] = k[0];
        m[1][2] = k[0];
      end
      MODE_SCALAR_XYZ: begin
        m[0][1] = k[0];
        m[1][2] = k[0];
        m[2][3] = k[0];
      end
      MODE_PROP_XY: begin
        m[0][1] = k[0];
        m[1][2] = k[1];
      end
      MODE_PROP_XYZ: begin
        m[0][1] = k[0];
        m[1][2] = k[1];
        m[2][3] = k[2];
      end
      MODE_LIN_SIMPLE_XY, MODE_LIN_SIMPLE_XYZ: begin
        m[0][0] = k[0];
        m[0][1] = k[1];
        m[1][0] = k[2];
        m[1][2] = k[3];
        if (mode_q == MODE_LIN_SIMPLE_XYZ) begin
          m[2][0] = k[4];
          m[2][3] = k[5];
        end
      end
      MODE_LIN_FULL_XY, MODE_LIN_FULL_XYZ: begin
        for (int j = 0; j < 4; j++) begin
          m[0][j] = k[j];
          m[1][j] = k[4 + j];
          if (mode_q == MODE_LIN_FULL_XYZ) m[2][j] = k[8 + j];
        end
      end
      default: ;
    endcase
    for (int r = 0; r < 3; r++)
      acc[r] = m[r][0] * 65536 + m[r][1] * dx + m[r][2] * dy + m[r][3] * dz * 8;
    ox = wrap32((acc[0] + 1024) >>> 11);
    oy = wrap32((acc[1] + 1024) >>> 11);
    oz = (acc[2] + 8192) >>> 14;
    if (oz > Q13_PI) oz = Q13_PI;
    if (oz < -Q13_PI) oz = -Q13_PI;
  endfunction

  function automatic void integrate_pose(input longint dx, input longint dy, input longint dz,
                                         inout longint x, inout longint y, inout longint h);
    longint c, s, wx, wy;
    cordic_cos_sin(h, c, s);
    rotate_vec(dx, dy, c, s, wx, wy);
    x = wrap32(x + wx);
    y = wrap32(y + wy);
    h = wrap_pi(h + dz);
  endfunction

  function automatic pose_t odometry_step(input logic [1:0] cmd, input longint px,
                                          input longint py, input longint ph, input bit ls);
    longint rx, ry, rh, c, s, vx, vy, dz, cx, cy, cz;
    bit     last;
    pose_t  p;
    if (cmd == CMD_SAMPLE) begin
      if (!started_q) begin
        prev_left_q = ls;
        anc_x = px;
        anc_y = py;
        anc_h = ph;
        started_q = 1;
      end
      last = prev_left_q;
      prev_left_q = ls;
      cordic_cos_sin(anc_h, c, s);
      rotate_vec(wrap32(px - anc_x), wrap32(py - anc_y), c, -s, vx, vy);
      dz = wrap_pi(ph - anc_h);
      apply_correction(vx, vy, dz, cx, cy, cz);
      if (!last && ls) begin
        integrate_pose(cx, cy, cz, odo_x, odo_y, odo_h);
        anc_x = px;
        anc_y = py;
        anc_h = ph;
        rx = odo_x;
        ry = odo_y;
        rh = odo_h;
      end else begin
        rx = odo_x;
        ry = odo_y;
        rh = odo_h;
        integrate_pose(cx, cy, cz, rx, ry, rh);
      end
    end else if (cmd == CMD_STEP) begin
      if (!started_q) begin
        prev_left_q = 1;
        started_q = 1;
      end
      apply_correction(px, py, ph, cx, cy, cz);
      anc_x = odo_x;
      anc_y = odo_y;
      anc_h = odo_h;
      integrate_pose(cx, cy, cz, odo_x, odo_y, odo_h);
      rx = odo_x;
      ry = odo_y;
      rh = odo_h;
    end else begin
      started_q = 0;
      odo_x = px;
      odo_y = py;
      odo_h = wrap_pi(ph);
      rx = odo_x;
      ry = odo_y;
      rh = odo_h;
    end
    p.x = rx[31:0];
    p.y = ry[31:0];
    p.h = rh[15:0];
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t want, got;
    if (!rst_ni) begin
      mode_q = '0;
      coef_q[0] = '0;
      coef_q[1] = '0;
      coef_q[2] = '0;
      started_q = 0;
      prev_left_q = 0;
      anc_x = 0;
      anc_y = 0;
      anc_h = 0;
      odo_x = 0;
      odo_y = 0;
      odo_h = 0;
      errors = 0;
      pose_fifo.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pose_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected pose word, expected none actual %h", $time, got);
        end else begin
          want = pose_fifo.pop_front();
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
          end
          if (got.y !== want.y) begin
            errors++;
            $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
          end
          if (got.h !== want.h) begin
            errors++;
            $display("%0t: out_heading expected %h actual %h", $time, want.h, got.h);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_NONE)
        pose_fifo.push_back(odometry_step(s_axis_tuser,
                                          longint'($signed(s_axis_tdata[31:0])),
                                          longint'($signed(s_axis_tdata[63:32])),
                                          longint'($signed(s_axis_tdata[79:64])),
                                          s_axis_tdata[80]));
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_MODE:      mode_q = pwdata[3:0];
          REG_COEF_LOW:  coef_q[0] = pwdata;
          REG_COEF_MID:  coef_q[1] = pwdata;
          REG_COEF_HIGH: coef_q[2] = pwdata;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import cso_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES = 14;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_SAMPLE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          sink_wait = 0;
  int          sink_draw;
  bit          calm = 0;
  int          counted;
  logic [31:0] walk_x, walk_y;
  logic [15:0] walk_h;
  bit          walk_left;

  always #6 clk_i = ~clk_i;

  corrected_step_odometry dut (.*);

  odo_checker u_checker (.*);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_draw = calm ? 0 : $urandom_range(0, 16);
      sink_wait <= sink_draw;
      m_axis_tready <= (sink_draw == 0);
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= sink_wait == 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] ph, input bit ls);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, ls, ph, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd != CMD_NONE) counted++;
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [63:0] coef_word(input int style);
    logic [63:0] w;
    for (int i = 0; i < 4; i++) begin
      case (style)
        0: w[16*i +: 16] = 16'h7fff;
        1: w[16*i +: 16] = 16'h8000;
        2: w[16*i +: 16] = $urandom;
        default: w[16*i +: 16] = 16'(2048 + $signed($urandom_range(0, 800)) - 400);
      endcase
    end
    return w;
  endfunction

  task automatic random_word;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_word(CMD_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end else if (r < 10) begin
      send_word(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end else if (r < 14) begin
      walk_x = $urandom;
      walk_y = $urandom;
      walk_h = 16'($signed($urandom_range(0, 51472)) - 25736);
      send_word(CMD_RESET, $urandom_range(0, 1) ? walk_x : 32'($signed(walk_x) >>> 12),
                walk_y, $urandom_range(0, 7) == 0 ? 16'($urandom) : walk_h, 0);
    end else if (r < 28) begin
      send_word(CMD_STEP, 32'($signed($urandom_range(0, 40000)) - 20000),
                32'($signed($urandom_range(0, 40000)) - 20000),
                16'($signed($urandom_range(0, 4000)) - 2000), $urandom_range(0, 1));
    end else begin
      walk_x = walk_x + 32'($signed($urandom_range(0, 8000)) - 2000);
      walk_y = walk_y + 32'($signed($urandom_range(0, 8000)) - 4000);
      walk_h = 16'(longint'($signed(walk_h)) + $signed($urandom_range(0, 1200)) - 600);
      if ($signed(walk_h) > 25736) walk_h = walk_h - 16'd51472;
      if ($signed(walk_h) < -25736) walk_h = walk_h + 16'd51472;
      if ($urandom_range(0, 3) == 0) walk_left = !walk_left;
      send_word(CMD_SAMPLE, walk_x, walk_y, walk_h, walk_left);
    end
  endtask

  initial begin
    int modes [PHASES] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 15, 9, 7};
    counted = 0;
    walk_x = '0;
    walk_y = '0;
    walk_h = '0;
    walk_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_SAMPLE, 32'h0001_0000, 32'h0000_8000, 16'd100, 0);
    send_word(CMD_SAMPLE, 32'h0002_0000, 32'h0001_0000, 16'd300, 1);
    send_word(CMD_SAMPLE, 32'h0003_0000, 32'h0001_8000, 16'd500, 0);
    send_word(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1);
    send_word(CMD_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 1);
    send_word(CMD_RESET, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 0);
    send_word(CMD_RESET, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 1);
    send_word(CMD_STEP, 32'h0000_8000, 32'hffff_8000, 16'd25736, 0);
    send_word(CMD_STEP, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 1);
    send_word(CMD_RESET, 32'h0, 32'h0, 16'd25736, 0);
    send_word(CMD_STEP, 32'h8000_0000, 32'h8000_0000, 16'h8000, 0);
    send_word(CMD_RESET, 32'h0, 32'h0, 16'hc000, 0);
    send_word(CMD_SAMPLE, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 1);
    send_word(CMD_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 0);
    send_word(CMD_SAMPLE, 32'h0, 32'h0, 16'd0, 1);
    send_word(CMD_NONE, 32'h0, 32'h0, 16'd0, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p % 4 == 3);
      apb_write(REG_MODE, 64'(modes[p]));
      apb_write(REG_COEF_LOW, coef_word(p == 2 ? 0 : p == 4 ? 1 : p % 3 == 1 ? 2 : 3));
      apb_write(REG_COEF_MID, p == 12 ? 64'hffff_ffff_ffff_ffff : coef_word(p % 5 == 0 ? 2 : 3));
      apb_write(REG_COEF_HIGH, p == 12 ? 64'h0 : coef_word(p == 13 ? 0 : p % 2 == 0 ? 2 : 3));
      counted = 0;
      while (counted < 110) random_word();
      drain();
    end
    calm = 0;

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
